[hdl/gmcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared types, constants and helpers for the grid min-cost path block.
// ----------------------------------------------------------------------------
package gmcp_pkg;

    localparam int COST_W       = 32;
    localparam int CELL_W       = 16;
    localparam int CFG_W        = 4;
    localparam int MAX_ROWS_DEF = 8;

    localparam logic [CFG_W-1:0]  ROWS_RESET = 4'd3;
    localparam logic [COST_W-1:0] COST_SAT   = 32'hFFFF_FFFF;

    // one column store entry: reachable flag plus path cost
    typedef struct packed {
        logic              reach;
        logic [COST_W-1:0] cost;
    } entry_t;

    localparam entry_t ENTRY_NONE = '{reach: 1'b0, cost: '0};

    // per-cell control handed to the cell unit
    typedef struct packed {
        logic up_en;
        logic down_en;
        logic blocked;
        logic first;
    } cell_ctl_t;

    // least reachable of two entries; unreachable only if both are
    function automatic entry_t entry_min(input entry_t a, input entry_t b);
        entry_t res;
        if (!a.reach)
        begin
            res = b;
        end
        else if (!b.reach)
        begin
            res = a;
        end
        else if (b.cost < a.cost)
        begin
            res = b;
        end
        else
        begin
            res = a;
        end
        return res;
    endfunction

endpackage

[hdl/gmcp_col_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_col_ram
// Column store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gmcp_col_ram #(
    parameter int DEPTH = gmcp_pkg::MAX_ROWS_DEF,
    parameter int AW    = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  gmcp_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output gmcp_pkg::entry_t  rd_data_a,
    output gmcp_pkg::entry_t  rd_data_b
);

    gmcp_pkg::entry_t mem [DEPTH];
    gmcp_pkg::entry_t rd_a_reg;
    gmcp_pkg::entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[hdl/gmcp_cell_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_cell_unit
// Three-way neighbor min plus saturating add of the cell cost.
// ----------------------------------------------------------------------------
module gmcp_cell_unit (
    input  gmcp_pkg::entry_t                nbr_up,
    input  gmcp_pkg::entry_t                nbr_mid,
    input  gmcp_pkg::entry_t                nbr_down,
    input  gmcp_pkg::cell_ctl_t             ctl,
    input  logic [gmcp_pkg::CELL_W-1:0]     cell_cost,
    output gmcp_pkg::entry_t                new_entry
);

    gmcp_pkg::entry_t              up_q;
    gmcp_pkg::entry_t              down_q;
    gmcp_pkg::entry_t              best;
    logic [gmcp_pkg::COST_W:0]     sum;

    always_comb
    begin
        up_q   = ctl.up_en   ? nbr_up   : gmcp_pkg::ENTRY_NONE;
        down_q = ctl.down_en ? nbr_down : gmcp_pkg::ENTRY_NONE;
        best   = gmcp_pkg::entry_min(gmcp_pkg::entry_min(up_q, nbr_mid), down_q);
        sum    = {1'b0, best.cost} + (gmcp_pkg::COST_W + 1)'(cell_cost);

        if (ctl.blocked)
        begin
            new_entry = gmcp_pkg::ENTRY_NONE;
        end
        else if (ctl.first)
        begin
            new_entry.reach = 1'b1;
            new_entry.cost  = gmcp_pkg::COST_W'(cell_cost);
        end
        else if (best.reach)
        begin
            new_entry.reach = 1'b1;
            // carry out means the sum passed the field maximum
            new_entry.cost  = sum[gmcp_pkg::COST_W] ? gmcp_pkg::COST_SAT
                                                    : sum[gmcp_pkg::COST_W-1:0];
        end
        else
        begin
            new_entry = gmcp_pkg::ENTRY_NONE;
        end
    end

endmodule

[hdl/grid_min_cost_path_blocked.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path_blocked
// Streaming min-cost path over a grid with blocked cells, three moves per step.
// ----------------------------------------------------------------------------
// Usage:
//  - Cells arrive on the s_axis request channel in column-major order, rows
//    0 .. rows_in_use-1 of each column. tdata = cell cost, tuser = blocked,
//    tlast = last cell of the grid.
//  - cfg_wr_en/cfg_wr_data write rows_in_use (0 acts as 1, values above
//    MAX_ROWS act as MAX_ROWS). Write only while the block is idle.
//  - One result per grid on m_axis: tdata = best cost over the final column
//    (0 if none), tuser = path found. Cells without tlast give no result.
//  - Throughput: one cell per cycle unless stalled. Stage 1 issues two column
//    store reads (own row and row below); stage 2 does min/add and writes
//    back. The row above comes from a held register; a write-to-read bypass
//    covers short columns where the next column's reads meet the pending
//    write. A result passes stage 2 and the output register to m_axis.
//  - The best cost of the final column is tracked as a running min, so no
//    sweep over the store is needed at grid end.
//  - Backpressure: while a result waits on m_axis, cells keep flowing; only a
//    second grid end that finds the result register still full holds
//    s_axis_tready low until the receiver takes the first.
//  - Reset clears the row position, first-column flag, entry valid bits and
//    the output register; rows_in_use returns to 3. No clearing pass needed.
// ----------------------------------------------------------------------------
module grid_min_cost_path_blocked #(
    parameter int MAX_ROWS = gmcp_pkg::MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [gmcp_pkg::CFG_W-1:0]    cfg_wr_data,   // rows_in_use

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [gmcp_pkg::CELL_W-1:0]   s_axis_tdata,  // [15:0] cell_cost
    input  logic [0:0]                    s_axis_tuser,  // [0] cell_blocked
    input  logic                          s_axis_tlast,  // grid_end

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [gmcp_pkg::COST_W-1:0]   m_axis_tdata,  // [31:0] best_cost
    output logic [0:0]                    m_axis_tuser   // [0] path_found
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW = $clog2(MAX_ROWS + 1);

    // ---------------- configuration ----------------
    logic [gmcp_pkg::CFG_W-1:0] rows_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= gmcp_pkg::ROWS_RESET;
        end
        else if (cfg_wr_en)
        begin
            rows_cfg_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 1: row tracking and store reads ----------------
    logic          accept;
    logic          s2_go;
    logic [RW-1:0] rows_eff;
    logic          wrap;
    logic [AW-1:0] cur_row;
    logic          cur_first;
    logic [RW-1:0] row_plus;
    logic          has_up;
    logic          has_down;
    logic [AW-1:0] rd_b_addr;
    logic          fwd_a;
    logic          fwd_b;

    logic [AW-1:0] row_pos_reg;
    logic [AW-1:0] row_pos_next;
    logic          first_col_reg;
    logic          first_col_next;

    logic [MAX_ROWS-1:0] entry_vld_reg;

    // stage 2 registers
    logic                         s2_valid_reg;
    logic [AW-1:0]                s2_row_reg;
    logic [gmcp_pkg::CELL_W-1:0]  s2_cost_reg;
    logic                         s2_end_reg;
    gmcp_pkg::cell_ctl_t          s2_ctl_reg;
    logic                         fwd_a_reg;
    logic                         fwd_b_reg;
    logic                         vld_a_reg;
    logic                         vld_b_reg;

    always_comb
    begin
        // clamp the row count to 1 .. MAX_ROWS
        if (rows_cfg_reg == '0)
        begin
            rows_eff = RW'(1);
        end
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = RW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RW'(rows_cfg_reg);
        end

        // row count shrank under the current position: start a new column
        wrap      = RW'(row_pos_reg) >= rows_eff;
        cur_row   = wrap ? '0 : row_pos_reg;
        cur_first = wrap ? 1'b0 : first_col_reg;
        row_plus  = RW'(cur_row) + RW'(1);
        has_up    = cur_row != '0;
        has_down  = row_plus < rows_eff;
        rd_b_addr = has_down ? row_plus[AW-1:0] : cur_row;

        // stage 2 writes this edge; bypass if it hits a row read now
        fwd_a = s2_go && (s2_row_reg == cur_row);
        fwd_b = s2_go && (s2_row_reg == rd_b_addr);

        if (s_axis_tlast)
        begin
            row_pos_next   = '0;
            first_col_next = 1'b1;
        end
        else if (!has_down)
        begin
            row_pos_next   = '0;
            first_col_next = 1'b0;
        end
        else
        begin
            row_pos_next   = row_plus[AW-1:0];
            first_col_next = cur_first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            first_col_reg <= 1'b1;
        end
        else if (accept)
        begin
            row_pos_reg   <= row_pos_next;
            first_col_reg <= first_col_next;
        end
    end

    // ---------------- column store ----------------
    gmcp_pkg::entry_t rd_data_a;
    gmcp_pkg::entry_t rd_data_b;
    gmcp_pkg::entry_t new_entry;

    gmcp_col_ram #(
        .DEPTH (MAX_ROWS),
        .AW    (AW)
    ) u_col_ram (
        .clk       (clk),
        .wr_en     (s2_go),
        .wr_addr   (s2_row_reg),
        .wr_data   (new_entry),
        .rd_en     (accept),
        .rd_addr_a (cur_row),
        .rd_addr_b (rd_b_addr),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // entry valid bits: an entry not written since grid start reads unreachable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
        end
        else if (s2_go)
        begin
            if (s2_end_reg)
            begin
                entry_vld_reg <= '0;
            end
            else
            begin
                entry_vld_reg[s2_row_reg] <= 1'b1;
            end
        end
    end

    // ---------------- stage 2 pipeline register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_row_reg         <= cur_row;
            s2_cost_reg        <= s_axis_tdata;
            s2_end_reg         <= s_axis_tlast;
            s2_ctl_reg.up_en   <= has_up;
            s2_ctl_reg.down_en <= has_down;
            s2_ctl_reg.blocked <= s_axis_tuser[0];
            s2_ctl_reg.first   <= cur_first;
            fwd_a_reg          <= fwd_a;
            fwd_b_reg          <= fwd_b;
            vld_a_reg          <= entry_vld_reg[cur_row];
            vld_b_reg          <= entry_vld_reg[rd_b_addr];
        end
    end

    // ---------------- stage 2: compute and write back ----------------
    gmcp_pkg::entry_t held_reg;      // previous column's value of the row above
    gmcp_pkg::entry_t last_wr_reg;   // last entry written, for the bypass
    gmcp_pkg::entry_t col_min_reg;   // running min of the current column
    gmcp_pkg::entry_t nbr_mid;
    gmcp_pkg::entry_t nbr_down;
    gmcp_pkg::entry_t col_min_next;

    logic                        out_valid_reg;
    logic [gmcp_pkg::COST_W-1:0] out_cost_reg;
    logic                        out_found_reg;

    always_comb
    begin
        if (fwd_a_reg)
        begin
            nbr_mid = last_wr_reg;
        end
        else
        begin
            nbr_mid.reach = vld_a_reg && rd_data_a.reach;
            nbr_mid.cost  = rd_data_a.cost;
        end

        if (fwd_b_reg)
        begin
            nbr_down = last_wr_reg;
        end
        else
        begin
            nbr_down.reach = vld_b_reg && rd_data_b.reach;
            nbr_down.cost  = rd_data_b.cost;
        end

        col_min_next = gmcp_pkg::entry_min(
            (s2_row_reg == '0) ? gmcp_pkg::ENTRY_NONE : col_min_reg, new_entry);
    end

    gmcp_cell_unit u_cell_unit (
        .nbr_up    (held_reg),
        .nbr_mid   (nbr_mid),
        .nbr_down  (nbr_down),
        .ctl       (s2_ctl_reg),
        .cell_cost (s2_cost_reg),
        .new_entry (new_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= gmcp_pkg::ENTRY_NONE;
        end
        else if (s2_go)
        begin
            held_reg <= nbr_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            last_wr_reg <= new_entry;
            col_min_reg <= col_min_next;
        end
    end

    // ---------------- output register ----------------
    // stage 2 holds only when its grid end finds the output still full
    assign s2_go  = s2_valid_reg && !(s2_end_reg && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !s2_valid_reg || s2_go;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_go && s2_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_end_reg)
        begin
            out_cost_reg  <= col_min_next.reach ? col_min_next.cost : '0;
            out_found_reg <= col_min_next.reach;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_cost_reg;
    assign m_axis_tuser[0] = out_found_reg;

endmodule

[hdl/gmcp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_checker
// Port-level checks for the grid min-cost path block, bound to the top.
// ----------------------------------------------------------------------------
module gmcp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gmcp_pkg::COST_W-1:0]   m_axis_tdata,
    input logic [0:0]                    m_axis_tuser
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // not-found result carries zero cost
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero cost");

    // a fresh result traces back to an accepted grid-end request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a grid-end request");

    // input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready) || m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind grid_min_cost_path_blocked gmcp_checker u_gmcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/grid_min_cost_path_blocked_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path_blocked_chk
// Watches the config, cell and result channels, tracks the path-cost column
// and compares every result with the predicted grid minimum.
// ----------------------------------------------------------------------------
module grid_min_cost_path_blocked_chk #(
    parameter int MAX_ROWS = gmcp_pkg::MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gmcp_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [gmcp_pkg::CELL_W-1:0]   s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,
    input  logic                          s_axis_tlast,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [gmcp_pkg::COST_W-1:0]   m_axis_tdata,
    input  logic [0:0]                    m_axis_tuser,
    output int                            mismatches,
    output int                            pending,
    output int                            cells_seen,
    output int                            grids_checked,
    output int                            paths_found,
    output int                            saturated_seen
);

    import gmcp_pkg::*;

    typedef struct packed {
        logic [COST_W-1:0] best;
        logic              found;
    } grid_result_t;

    logic [CFG_W-1:0] rows_cfg;
    entry_t           col_store [MAX_ROWS];
    entry_t           row_above;      // previous-column value of the row above
    int unsigned      row_pos;
    logic             first_col;
    grid_result_t     results_due [$];

    function automatic int unsigned active_rows();
        if (rows_cfg == 0)
        begin
            return 1;
        end
        if (rows_cfg > MAX_ROWS)
        begin
            return MAX_ROWS;
        end
        return rows_cfg;
    endfunction

    // keeps acc on ties
    function automatic entry_t cheaper(input entry_t acc, input entry_t cand);
        if (cand.reach && (!acc.reach || cand.cost < acc.cost))
        begin
            return cand;
        end
        return acc;
    endfunction

    function automatic void start_column();
        row_pos   = 0;
        row_above = ENTRY_NONE;
        first_col = 1'b0;
    endfunction

    function automatic void clear_grid();
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            col_store[i] = ENTRY_NONE;
        end
        row_above = ENTRY_NONE;
        row_pos   = 0;
        first_col = 1'b1;
    endfunction

    function automatic void advance_grid(input logic [CELL_W-1:0] cost,
                                         input logic blocked, input logic last);
        int unsigned     nrows;
        int unsigned     r;
        entry_t          fresh;
        entry_t          pick;
        logic [COST_W:0] sum;
        grid_result_t    res;
        nrows = active_rows();
        // row count dropped under the position: new, non-first column
        if (row_pos >= nrows)
        begin
            start_column();
        end
        r     = row_pos;
        fresh = ENTRY_NONE;
        if (!blocked)
        begin
            if (first_col)
            begin
                fresh.reach = 1'b1;
                fresh.cost  = COST_W'(cost);
            end
            else
            begin
                pick = ENTRY_NONE;
                if (r > 0)
                begin
                    pick = cheaper(pick, row_above);
                end
                pick = cheaper(pick, col_store[r]);
                if (r + 1 < nrows)
                begin
                    pick = cheaper(pick, col_store[r + 1]);
                end
                if (pick.reach)
                begin
                    sum         = {1'b0, pick.cost} + (COST_W + 1)'(cost);
                    fresh.reach = 1'b1;
                    fresh.cost  = sum[COST_W] ? COST_SAT : sum[COST_W-1:0];
                end
            end
        end
        row_above    = col_store[r];
        col_store[r] = fresh;
        if (last)
        begin
            pick = ENTRY_NONE;
            for (int unsigned i = 0; i <= r; i++)
            begin
                pick = cheaper(pick, col_store[i]);
            end
            res.best  = pick.reach ? pick.cost : '0;
            res.found = pick.reach;
            results_due.push_back(res);
            clear_grid();
        end
        else if (r + 1 >= nrows)
        begin
            start_column();
        end
        else
        begin
            row_pos = r + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t want;
        if (!rst_n)
        begin
            rows_cfg = ROWS_RESET;
            clear_grid();
            results_due.delete();
            mismatches     = 0;
            pending        = 0;
            cells_seen     = 0;
            grids_checked  = 0;
            paths_found    = 0;
            saturated_seen = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rows_cfg = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cells_seen++;
                advance_grid(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result with none due: best_cost=%0d path_found=%0b",
                                 $realtime, m_axis_tdata, m_axis_tuser[0]);
                    end
                end
                else
                begin
                    want = results_due.pop_front();
                    grids_checked++;
                    if (want.found)
                    begin
                        paths_found++;
                    end
                    if (want.found && want.best == COST_SAT)
                    begin
                        saturated_seen++;
                    end
                    if (m_axis_tdata !== want.best || m_axis_tuser[0] !== want.found)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: grid %0d: best_cost exp %0d got %0d, path_found exp %0b got %0b",
                                     $realtime, grids_checked, want.best, m_axis_tdata,
                                     want.found, m_axis_tuser[0]);
                        end
                    end
                end
            end
            pending = results_due.size();
        end
    end

endmodule

[dv/grid_min_cost_path_blocked_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path_blocked_tb
// Drives cell grids into the min-cost path block under several row counts,
// with random gaps and result backpressure; the checker predicts each grid's
// best cost and the top reports the verdict.
// ----------------------------------------------------------------------------
module grid_min_cost_path_blocked_tb;

    import gmcp_pkg::*;

    localparam int MAX_ROWS    = MAX_ROWS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    // cells per random phase; 12 phases give roughly 1750 requests
    localparam int PHASE_CELLS = 135;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CELL_W-1:0]   s_axis_tdata = '0;   // [15:0] cell_cost
    logic [0:0]          s_axis_tuser = '0;   // [0] cell_blocked
    logic                s_axis_tlast = 1'b0; // grid_end
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [COST_W-1:0]   m_axis_tdata;        // [31:0] best_cost
    logic [0:0]          m_axis_tuser;        // [0] path_found

    // no_idle turns off gaps on both sides for one long stretch
    logic                no_idle = 1'b0;
    int                  cycles = 0;
    int                  settings_used = 0;

    int                  mismatches;
    int                  pending;
    int                  cells_seen;
    int                  grids_checked;
    int                  paths_found;
    int                  saturated_seen;

    grid_min_cost_path_blocked #(
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    grid_min_cost_path_blocked_chk #(
        .MAX_ROWS (MAX_ROWS)
    ) path_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatches     (mismatches),
        .pending        (pending),
        .cells_seen     (cells_seen),
        .grids_checked  (grids_checked),
        .paths_found    (paths_found),
        .saturated_seen (saturated_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("grid_min_cost_path_blocked_tb: errors");
            $finish;
        end
    end

    // result side: ready low about 20 percent of the time
    always @(posedge clk)
    begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    // One cell request; valid stays high into the next request when no gap
    // is drawn. Acceptance is seen on pre-edge values right after the edge.
    task automatic send_cell(input logic [CELL_W-1:0] cost, input logic blocked,
                             input logic last);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 20)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cost;
        s_axis_tuser  <= blocked;
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // Hold the sender until every predicted result is out, then let the
    // pipeline run dry in case cells are still in flight.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rows(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // extremes weighted up so large sums and zero costs appear
    function automatic logic [CELL_W-1:0] pick_cost();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            return '0;
        end
        if (sel < 30)
        begin
            return '1;
        end
        if (sel < 50)
        begin
            return CELL_W'($urandom_range(1, 15));
        end
        return CELL_W'($urandom);
    endfunction

    // Column-major grid of random content; a few end early on a random cell.
    task automatic send_random_grid(input int unsigned nrows, inout int sent);
        int unsigned ncols;
        int unsigned total;
        int unsigned stop_at;
        int unsigned block_pct;
        ncols     = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                : $urandom_range(1, 4);
        total     = ncols * nrows;
        stop_at   = ($urandom_range(0, 99) < 8) ? $urandom_range(0, total - 1)
                                                : total - 1;
        block_pct = $urandom_range(0, 2) * 20;
        for (int unsigned k = 0; k <= stop_at; k++)
        begin
            send_cell(pick_cost(), $urandom_range(0, 99) < block_pct, k == stop_at);
            sent++;
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] row_plan [12];
        int unsigned      nrows;
        int               sent;

        row_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd4, 4'd7, 4'd9,
                     4'd5, 4'd3, 4'd6, 4'd8};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset row count of 3 ----
        // first column only holds the cell's own cost; all-zero/all-one costs
        send_cell(16'd5, 1'b0, 1'b0);
        send_cell(16'hFFFF, 1'b0, 1'b0);
        send_cell(16'd0, 1'b0, 1'b0);
        send_cell(16'd0, 1'b0, 1'b0);
        send_cell(16'd0, 1'b1, 1'b0);
        send_cell(16'hFFFF, 1'b0, 1'b1);
        // every cell blocked: not found, cost reported as zero
        send_cell(16'hFFFF, 1'b1, 1'b0);
        send_cell(16'd3, 1'b1, 1'b0);
        send_cell(16'd0, 1'b1, 1'b1);
        // grid end on row 0 of the first column
        send_cell(16'd9, 1'b0, 1'b1);
        // lone reachable row 2 feeds rows 1 and 2; row 0 has no reachable neighbor
        send_cell(16'd1, 1'b1, 1'b0);
        send_cell(16'd1, 1'b1, 1'b0);
        send_cell(16'd4, 1'b0, 1'b0);
        send_cell(16'd2, 1'b0, 1'b0);
        send_cell(16'd7, 1'b0, 1'b0);
        send_cell(16'd3, 1'b0, 1'b1);

        // row count cut below the position mid-column: next cell opens a
        // new, non-first column at row 0
        send_cell(16'd10, 1'b0, 1'b0);
        send_cell(16'd20, 1'b0, 1'b0);
        settle();
        write_rows(4'd2);
        send_cell(16'd1, 1'b0, 1'b0);
        send_cell(16'd2, 1'b0, 1'b1);
        // row count raised mid-column, then an early end in the next column
        send_cell(16'd6, 1'b0, 1'b0);
        settle();
        write_rows(4'd5);
        send_cell(16'd8, 1'b0, 1'b0);
        send_cell(16'd0, 1'b0, 1'b0);
        send_cell(16'hFFFF, 1'b1, 1'b0);
        send_cell(16'd2, 1'b0, 1'b0);
        send_cell(16'd1, 1'b0, 1'b0);
        send_cell(16'd1, 1'b0, 1'b1);

        // ---- random phases, one row setting each, idle between writes ----
        for (int p = 0; p < 12; p++)
        begin
            settle();
            write_rows(row_plan[p]);
            nrows = (row_plan[p] == 0) ? 1 :
                    (row_plan[p] > MAX_ROWS) ? MAX_ROWS : row_plan[p];
            // one phase runs with no gaps on either side
            no_idle <= (p == 6);
            sent = 0;
            while (sent < PHASE_CELLS)
            begin
                send_random_grid(nrows, sent);
            end
        end
        no_idle <= 1'b0;

        // drain: every result in, then a wait for stray output
        settle();
        repeat (8) @(posedge clk);

        $display("covered %0d cells in %0d checked grids (%0d with a path, %0d saturated)",
                 cells_seen, grids_checked, paths_found, saturated_seen);
        $display("across %0d row-count writes, with gaps, backpressure and mid-column changes",
                 settings_used);
        if (mismatches == 0 && pending == 0)
        begin
            $display("grid_min_cost_path_blocked_tb: clean");
        end
        else
        begin
            $display("grid_min_cost_path_blocked_tb: errors");
        end
        $finish;
    end

endmodule

[grid_min_cost_path_blocked.f]
hdl/gmcp_pkg.sv
hdl/gmcp_col_ram.sv
hdl/gmcp_cell_unit.sv
hdl/grid_min_cost_path_blocked.sv
hdl/gmcp_checker.sv
dv/grid_min_cost_path_blocked_chk.sv
dv/grid_min_cost_path_blocked_tb.sv
